FILE: rtl/gtr_pkg.sv
// glyph text renderer: shared types and constants
// used by every file of the block; no dependencies
`timescale 1ns / 1ps

package gtr_pkg;

	// field widths
	localparam int FONT_ADDR_W = 11;
	localparam int GLYPH_COLS  = 5;
	localparam int GLYPH_ROWS  = 8;
	localparam int CELL_COLS   = 6;
	localparam int CELL_BITS   = GLYPH_COLS * GLYPH_ROWS;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 3;

	// operation codes
	localparam logic [1:0] OP_LOAD_FONT  = 2'd0;
	localparam logic [1:0] OP_DRAW_CHAR  = 2'd1;
	localparam logic [1:0] OP_SET_CURSOR = 2'd2;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BACKGROUND    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_WRAP_ENABLE   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_CP437_ENABLE  = 3'd4;

	// special characters
	localparam logic [7:0] CHAR_NEWLINE = 8'd10;
	localparam logic [7:0] CHAR_CR      = 8'd13;
	localparam logic [7:0] CP_SHIFT_MIN = 8'd176;

	typedef struct packed {
		logic [1:0]             op;
		logic [7:0]             char_code;
		logic [15:0]            fg_color;
		logic [4:0]             char_scale;
		logic signed [15:0]     start_x;
		logic signed [15:0]     end_x;
		logic [FONT_ADDR_W-1:0] font_address;
		logic [7:0]             font_data;
		logic signed [15:0]     new_cursor_x;
		logic signed [15:0]     new_cursor_y;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] rect_x;
		logic signed [15:0] rect_y;
		logic [4:0]         rect_width;
		logic [4:0]         rect_height;
		logic [15:0]        rect_color;
		logic               last_rect;
	} rect_item_t;

	// font memory access for one cycle
	typedef struct packed {
		logic                   wr_en;
		logic [FONT_ADDR_W-1:0] wr_addr;
		logic [7:0]             wr_data;
		logic                   rd_en;
		logic [FONT_ADDR_W-1:0] rd_addr;
	} font_req_t;

	// one character cell handed to the raster scanner
	typedef struct packed {
		logic signed [15:0]   x;
		logic signed [15:0]   y;
		logic [4:0]           size;
		logic [15:0]          fg;
		logic [15:0]          bg;
		logic [CELL_BITS-1:0] bits;
		logic [CELL_BITS-1:0] mask;
	} rast_job_t;

endpackage

FILE: rtl/gtr_in_if.sv
// glyph text renderer: input item channel
// depends on gtr_pkg
`timescale 1ns / 1ps

interface gtr_in_if;
	logic             valid;
	logic             ready;
	gtr_pkg::in_item_t item;

	modport source(output valid, output item, input ready);
	modport sink(input valid, input item, output ready);
endinterface

FILE: rtl/gtr_out_if.sv
// glyph text renderer: rectangle result channel
// depends on gtr_pkg
`timescale 1ns / 1ps

interface gtr_out_if;
	logic               valid;
	logic               ready;
	gtr_pkg::rect_item_t item;

	modport source(output valid, output item, input ready);
	modport sink(input valid, input item, output ready);
endinterface

FILE: rtl/gtr_font_ram.sv
// glyph text renderer: font column memory, one write and one read port
// depends on gtr_pkg
`timescale 1ns / 1ps

module gtr_font_ram #(
	parameter int DEPTH = 1280
) (
	input  logic               clk,
	input  gtr_pkg::font_req_t req,
	output logic [7:0]         rd_data
);
	localparam int ADDR_W = $clog2(DEPTH);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr[ADDR_W-1:0]] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr[ADDR_W-1:0]];
		end
	end
endmodule

FILE: rtl/gtr_raster.sv
// glyph text renderer: cell scanner, one glyph position per cycle unless the output stalls, output register
// depends on gtr_pkg and gtr_out_if
`timescale 1ns / 1ps

module gtr_raster (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  gtr_pkg::rast_job_t job,
	output logic               busy,
	gtr_out_if.source          out_ch
);
	localparam int NB = gtr_pkg::CELL_BITS;

	logic                 busy_q;
	logic                 ovalid_q;
	logic [NB-1:0]        bits_q;
	logic [NB-1:0]        mask_q;
	logic [2:0]           row_q;
	logic signed [15:0]   rx_q;
	logic signed [15:0]   ry_q;
	logic signed [15:0]   y_q;
	logic [4:0]           size_q;
	logic [15:0]          fg_q;
	logic [15:0]          bg_q;
	gtr_pkg::rect_item_t  rect_q;

	logic slot_free;
	logic step;
	logic emit;
	logic last;

	assign slot_free = !ovalid_q || out_ch.ready;
	assign step      = busy_q && (!mask_q[0] || slot_free);
	assign emit      = busy_q && mask_q[0] && slot_free;
	assign last      = ~|mask_q[NB-1:1];

	assign busy         = busy_q;
	assign out_ch.valid = ovalid_q;
	assign out_ch.item  = rect_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			ovalid_q <= 1'b0;
			row_q    <= '0;
		end else begin
			if (start) begin
				busy_q <= |job.mask;
				row_q  <= '0;
			end else if (step) begin
				busy_q <= !last;
				row_q  <= (row_q == 3'(gtr_pkg::GLYPH_ROWS - 1)) ? '0 : row_q + 3'd1;
			end
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (out_ch.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bits_q <= job.bits;
			mask_q <= job.mask;
			rx_q   <= job.x;
			ry_q   <= job.y;
			y_q    <= job.y;
			size_q <= job.size;
			fg_q   <= job.fg;
			bg_q   <= job.bg;
		end else if (step) begin
			bits_q <= bits_q >> 1;
			mask_q <= mask_q >> 1;
			if (row_q == 3'(gtr_pkg::GLYPH_ROWS - 1)) begin
				rx_q <= rx_q + 16'(size_q);
				ry_q <= y_q;
			end else begin
				ry_q <= ry_q + 16'(size_q);
			end
		end
		if (emit) begin
			rect_q.rect_x      <= rx_q;
			rect_q.rect_y      <= ry_q;
			rect_q.rect_width  <= size_q;
			rect_q.rect_height <= size_q;
			rect_q.rect_color  <= bits_q[0] ? fg_q : bg_q;
			rect_q.last_rect   <= last;
		end
	end

`ifndef SYNTHESIS
	a_busy_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (mask_q != '0))
		else $error("scanner busy with no cell left to emit");
	a_last_ends_job: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last && !start) |=> !busy_q)
		else $error("scanner still busy after final rectangle");
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && !out_ch.ready) |=> (ovalid_q && $stable(rect_q)))
		else $error("rectangle changed or dropped while stalled");
`endif
endmodule

FILE: rtl/glyph_text_renderer_unit.sv
// glyph text renderer top level: item decode, cursor, clipping, font reads
// depends on gtr_pkg, gtr_in_if, gtr_out_if, gtr_font_ram, gtr_raster
`timescale 1ns / 1ps

// Text renderer for a 5x8 column font. Each input transaction loads one font
// byte, moves the cursor, or draws one character; a drawn character comes out
// as up to forty scaled squares (column 0..4, row 0..7 within a column), the
// final one flagged with last_rect. Font loads and cursor moves complete at
// acceptance, so they can stream at one per cycle. A character passes through
// the front-end control states in order: ST_PREP for newline and wrap handling,
// ST_CLIP for clipping and the cursor advance, ST_LOAD to read its five
// columns from the font memory (one read per cycle, registered read data),
// and ST_HAND to hand the cell over. The scanner then walks the cell one
// glyph bit per cycle while the output is not stalled, up to the last bit it
// has to emit. The front end takes new transactions while the scanner is
// busy; a following character waits at the handover until the scanner is
// free. Clipped cells, newlines and carriage returns produce no rectangles.
// The font memory is not cleared at reset and must be loaded before use.
module glyph_text_renderer_unit #(
	parameter int GLYPH_COUNT = 256,
	parameter int MAX_SCALE   = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	gtr_in_if.sink                              in_ch,
	gtr_out_if.source                           out_ch,
	input  logic                                cfg_wr_en,
	input  logic [gtr_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [gtr_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	localparam int         FONT_DEPTH  = GLYPH_COUNT * gtr_pkg::GLYPH_COLS;
	localparam int         NB          = gtr_pkg::CELL_BITS;
	// size never exceeds 31, so a larger limit never saturates
	localparam logic [4:0] MAX_SCALE_C = 5'(MAX_SCALE);

	typedef enum logic [2:0] {ST_IDLE, ST_PREP, ST_CLIP, ST_LOAD, ST_HAND} state_t;

	state_t state_q;

	// configuration
	logic [9:0]  screen_w_q;
	logic [9:0]  screen_h_q;
	logic [15:0] bg_q;
	logic        wrap_en_q;
	logic        cp437_q;

	// cursor
	logic signed [15:0] cur_col_q;
	logic signed [15:0] cur_row_q;

	// character being drawn
	logic [7:0]                     code_q;
	logic [15:0]                    fg_q;
	logic [4:0]                     size_q;
	logic signed [15:0]             start_x_q;
	logic signed [15:0]             end_x_q;
	logic signed [15:0]             x_q;
	logic signed [15:0]             y_q;
	logic                           gv_q;
	logic [gtr_pkg::FONT_ADDR_W-1:0] base_q;
	logic [2:0]                     issue_q;
	logic                           rdv_s1;
	logic [NB-1:0]                  bits_q;
	logic [NB-1:0]                  mask_q;

	logic                 accept;
	logic [4:0]           size_sat;
	logic                 issue;
	logic [7:0]           rd_data;
	logic                 raster_busy;
	logic                 start;
	logic                 bg_ne;
	logic [7:0]           col_bits;
	logic [7:0]           col_mask;
	gtr_pkg::font_req_t   fmem_req;
	gtr_pkg::rast_job_t   job;

	// signed working values for wrap and clip tests, no wraparound
	logic signed [17:0] col_ext;
	logic signed [17:0] row_ext;
	logic signed [17:0] endx_ext;
	logic signed [17:0] s6_ext;
	logic signed [17:0] s8_ext;
	logic signed [17:0] sw_ext;
	logic signed [17:0] sh_ext;
	logic               wrap_hit;
	logic               clipped;
	logic [7:0]         code_map;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;

	// size clamp: zero draws at size one
	always_comb begin
		if (in_ch.item.char_scale == 5'd0) begin
			size_sat = 5'd1;
		end else if (int'(in_ch.item.char_scale) > MAX_SCALE) begin
			size_sat = MAX_SCALE_C;
		end else begin
			size_sat = in_ch.item.char_scale;
		end
	end

	always_comb begin
		col_ext  = 18'(cur_col_q);
		row_ext  = 18'(cur_row_q);
		endx_ext = 18'(end_x_q);
		s6_ext   = signed'(18'(size_q) * 18'(gtr_pkg::CELL_COLS));
		s8_ext   = signed'(18'(size_q) << 3);
		sw_ext   = signed'({8'b0, screen_w_q});
		sh_ext   = signed'({8'b0, screen_h_q});
		wrap_hit = wrap_en_q && ((col_ext + s6_ext) > endx_ext);
		clipped  = (col_ext >= sw_ext) || (row_ext >= sh_ext) ||
			((col_ext + s6_ext - 18'sd1) < 18'sd0) ||
			((row_ext + s8_ext - 18'sd1) < 18'sd0);
		// without code page 437, codes from 176 move up by one, 255 wraps to 0
		code_map = (!cp437_q && code_q >= gtr_pkg::CP_SHIFT_MIN) ? code_q + 8'd1 : code_q;
	end

	// font memory port
	assign issue = (state_q == ST_LOAD) && (issue_q < 3'(gtr_pkg::GLYPH_COLS));
	always_comb begin
		fmem_req.wr_en   = accept && (in_ch.item.op == gtr_pkg::OP_LOAD_FONT) &&
			(int'(in_ch.item.font_address) < FONT_DEPTH);
		fmem_req.wr_addr = in_ch.item.font_address;
		fmem_req.wr_data = in_ch.item.font_data;
		fmem_req.rd_en   = issue;
		fmem_req.rd_addr = base_q + gtr_pkg::FONT_ADDR_W'(issue_q);
	end

	// glyph codes beyond the font read as blank columns
	assign bg_ne    = (bg_q != fg_q);
	assign col_bits = gv_q ? rd_data : 8'h00;
	assign col_mask = col_bits | {8{bg_ne}};

	assign start = (state_q == ST_HAND) && !raster_busy;
	always_comb begin
		job.x    = x_q;
		job.y    = y_q;
		job.size = size_q;
		job.fg   = fg_q;
		job.bg   = bg_q;
		job.bits = bits_q;
		job.mask = mask_q;
	end

	// control state, configuration and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			screen_w_q <= 10'd240;
			screen_h_q <= 10'd320;
			bg_q       <= 16'd0;
			wrap_en_q  <= 1'b1;
			cp437_q    <= 1'b0;
			cur_col_q  <= '0;
			cur_row_q  <= '0;
			issue_q    <= '0;
			rdv_s1     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					gtr_pkg::REG_SCREEN_WIDTH:  screen_w_q <= cfg_wdata[9:0];
					gtr_pkg::REG_SCREEN_HEIGHT: screen_h_q <= cfg_wdata[9:0];
					gtr_pkg::REG_BACKGROUND:    bg_q       <= cfg_wdata;
					gtr_pkg::REG_WRAP_ENABLE:   wrap_en_q  <= cfg_wdata[0];
					gtr_pkg::REG_CP437_ENABLE:  cp437_q    <= cfg_wdata[0];
					default: ;
				endcase
			end
			rdv_s1 <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (in_ch.item.op)
							gtr_pkg::OP_DRAW_CHAR: state_q <= ST_PREP;
							gtr_pkg::OP_SET_CURSOR: begin
								cur_col_q <= in_ch.item.new_cursor_x;
								cur_row_q <= in_ch.item.new_cursor_y;
							end
							default: ;
						endcase
					end
				end
				ST_PREP: begin
					priority if (code_q == gtr_pkg::CHAR_NEWLINE) begin
						cur_col_q <= '0;
						cur_row_q <= cur_row_q + 16'({size_q, 3'b000});
						state_q   <= ST_IDLE;
					end else if (code_q == gtr_pkg::CHAR_CR) begin
						state_q <= ST_IDLE;
					end else begin
						if (wrap_hit) begin
							cur_col_q <= start_x_q;
							cur_row_q <= cur_row_q + 16'({size_q, 3'b000});
						end
						state_q <= ST_CLIP;
					end
				end
				ST_CLIP: begin
					// cursor advances whether or not the cell is visible
					cur_col_q <= cur_col_q + 16'(s6_ext);
					issue_q   <= '0;
					state_q   <= clipped ? ST_IDLE : ST_LOAD;
				end
				ST_LOAD: begin
					if (issue) begin
						issue_q <= issue_q + 3'd1;
					end
					if (rdv_s1 && issue_q == 3'(gtr_pkg::GLYPH_COLS)) begin
						state_q <= ST_HAND;
					end
				end
				ST_HAND: begin
					if (!raster_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// character payload
	always_ff @(posedge clk) begin
		if (accept) begin
			code_q    <= in_ch.item.char_code;
			fg_q      <= in_ch.item.fg_color;
			size_q    <= size_sat;
			start_x_q <= in_ch.item.start_x;
			end_x_q   <= in_ch.item.end_x;
		end
		if (state_q == ST_PREP) begin
			code_q <= code_map;
		end
		if (state_q == ST_CLIP) begin
			x_q    <= cur_col_q;
			y_q    <= cur_row_q;
			gv_q   <= int'(code_q) < GLYPH_COUNT;
			base_q <= (int'(code_q) < GLYPH_COUNT) ?
				gtr_pkg::FONT_ADDR_W'(code_q) * gtr_pkg::FONT_ADDR_W'(gtr_pkg::GLYPH_COLS) : '0;
		end
		// columns shift in from the top so column 0 ends in the low byte
		if (rdv_s1) begin
			bits_q <= {col_bits, bits_q[NB-1:8]};
			mask_q <= {col_mask, mask_q[NB-1:8]};
		end
	end

	gtr_font_ram #(
		.DEPTH(FONT_DEPTH)
	) u_font_ram (
		.clk     (clk),
		.req     (fmem_req),
		.rd_data (rd_data)
	);

	gtr_raster u_raster (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.job    (job),
		.busy   (raster_busy),
		.out_ch (out_ch)
	);

`ifndef SYNTHESIS
	a_read_in_load: assert property (@(posedge clk) disable iff (!arst_n)
		rdv_s1 |-> (state_q == ST_LOAD))
		else $error("font read data returned outside column load");
	a_hand_after_five: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HAND) |-> (issue_q == 3'(gtr_pkg::GLYPH_COLS)))
		else $error("cell handed over before all columns were read");
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fmem_req.wr_en |-> (state_q == ST_IDLE))
		else $error("font write outside idle");
`endif
endmodule
